// ----- rtl/core/plist_pkg.sv -----
// Package for the positional list engine: widths, codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int ENTRY_W  = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;

    localparam int IN_FIELDS_W  = CMD_W + POS_W + ENTRY_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STAT_W + ENTRY_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_RETRIEVE = 2'd2,
        OP_REPLACE  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_UNDER = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic put;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t     op;
        status_t status;
        logic    no_shift;
        logic    last;
        logic    out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/plist_ctrl.sv -----
// Controller FSM for the positional list engine.
// Depends on plist_pkg; drives plist_dp through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module plist_ctrl
    import plist_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.status != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (stat.op)
                        OP_ADD:
                        begin
                            if (stat.no_shift)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_REMOVE, OP_RETRIEVE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SCAN;
                        end
                        OP_REPLACE:
                        begin
                            state_next = S_PUT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.rd = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (stat.op == OP_ADD) ? S_PUT : S_DONE;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/plist_dp.sv -----
// Datapath for the positional list engine: list memory, shift cursor,
// status checks, entry count and output register. Depends on plist_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plist_dp
    import plist_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire ctrl_cmd_t              cmd,
    output dp_stat_t                    stat
);

    logic [ENTRY_W-1:0] mem [CAPACITY];

    op_t                op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ENTRY_W-1:0] val_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   cur_next;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   ra_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] res_reg;
    logic [ENTRY_W-1:0] res_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    logic [ENTRY_W-1:0] out_entry_reg;
    logic [CNT_W-1:0]   out_count_reg;

    status_t            status;
    logic [IDX_W-1:0]   pos_idx;
    logic [IDX_W-1:0]   last_idx;
    logic               we;
    logic [IDX_W-1:0]   wa;
    logic [ENTRY_W-1:0] wd;
    logic               capture;

    assign pos_idx  = pos_reg[IDX_W-1:0];
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        status = ST_OK;
        case (op_reg)
            OP_ADD:
            begin
                if (pos_reg > POS_W'(count_reg))
                    status = ST_RANGE;
                else if (count_reg >= CNT_W'(CAPACITY))
                    status = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (count_reg == '0)
                    status = ST_UNDER;
                else if (pos_reg >= POS_W'(count_reg))
                    status = ST_RANGE;
            end
            default:
            begin
                if (pos_reg >= POS_W'(count_reg))
                    status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.status   = status;
        stat.no_shift = (pos_reg == POS_W'(count_reg));
        stat.out_free = !out_valid_reg || m_tready;
        case (op_reg)
            OP_ADD:    stat.last = (cur_reg == pos_idx);
            OP_REMOVE: stat.last = (cur_reg == last_idx);
            default:   stat.last = 1'b1;
        endcase
    end

    // cursor walks down for add, up for remove
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.start)
            cur_next = (op_reg == OP_ADD) ? last_idx : pos_idx;
        else if (cmd.rd)
            cur_next = (op_reg == OP_ADD) ? cur_reg - IDX_W'(1) : cur_reg + IDX_W'(1);
    end

    always_comb
    begin
        we      = 1'b0;
        wa      = pos_idx;
        wd      = val_reg;
        capture = rd_valid_reg && (ra_reg == pos_idx)
                  && (op_reg == OP_REMOVE || op_reg == OP_RETRIEVE);
        if (cmd.put)
        begin
            we = 1'b1;
        end
        else if (rd_valid_reg)
        begin
            wd = rd_data_reg;
            if (op_reg == OP_ADD)
            begin
                we = 1'b1;
                wa = ra_reg + IDX_W'(1);
            end
            else if (op_reg == OP_REMOVE && ra_reg != pos_idx)
            begin
                we = 1'b1;
                wa = ra_reg - IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.load)
            res_next = '0;
        else if (capture)
            res_next = rd_data_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (status == ST_OK && op_reg == OP_ADD)
            count_next = count_reg + CNT_W'(1);
        else if (status == ST_OK && op_reg == OP_REMOVE)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (cmd.rd)
            rd_data_reg <= mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(s_tdata[CMD_W-1:0]);
            pos_reg <= s_tdata[CMD_W +: POS_W];
            val_reg <= s_tdata[CMD_W + POS_W +: ENTRY_W];
        end
        cur_reg <= cur_next;
        ra_reg  <= cur_reg;
        res_reg <= res_next;
        if (cmd.finish)
        begin
            out_status_reg <= status;
            out_entry_reg  <= res_reg;
            out_count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                count_reg <= count_next;
            rd_valid_reg  <= cmd.rd;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                       out_count_reg, out_entry_reg, out_status_reg};

endmodule
`default_nettype wire

// ----- rtl/core/positional_list_engine_core.sv -----
// Positional list engine top level: ties the controller FSM to the datapath.
// Depends on plist_pkg, plist_ctrl and plist_dp.
//
// Usage:
//   Input channel s_*: one command word per handshake (s_tvalid && s_tready).
//   Output channel m_*: one result word per command, in command order.
//   Each word carries add, remove, retrieve or replace at a list position;
//   the result gives status, the removed or retrieved entry, and the count.
//   Failed commands, replace and add at the tail go without a list walk;
//   retrieve reads one entry; add shifts (count - position) entries and
//   remove shifts (count - position - 1), one memory read and one write
//   per cycle. One command is in work at a time; s_tready is high only
//   between commands, so a new command is taken only after the last one
//   has finished.
//   The result sits in an output register: while the receiver stalls the
//   next command is still accepted and processed, then holds until the
//   register frees. Reset empties the list and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_core
    import plist_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // cmd[1:0], position[8:2], entry_in[40:9], zero pad above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status[1:0], entry_out[33:2], item_count_out[40:34], zero pad above
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    plist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plist_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
`default_nettype wire

// ----- rtl/core/plist_chk.sv -----
// Port-level checker for the positional list engine, bound to the top level.
// Depends on plist_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plist_chk
    import plist_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [STAT_W-1:0]  o_status;
    logic [ENTRY_W-1:0] o_entry;
    logic [CNT_W-1:0]   o_count;

    assign o_status = m_tdata[STAT_W-1:0];
    assign o_entry  = m_tdata[STAT_W +: ENTRY_W];
    assign o_count  = m_tdata[STAT_W + ENTRY_W +: CNT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while one is in work");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> o_count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_status != ST_OK |-> o_entry == '0)
        else $error("failed command returned an entry");

    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_status == ST_UNDER |-> o_count == '0)
        else $error("underflow reported on a non-empty list");

    logic unused_in;
    assign unused_in = ^s_tdata;

endmodule

bind positional_list_engine_core plist_chk u_plist_chk (.*);
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for positional_list_engine_core: a directed command table,
// then randomized add/remove/retrieve/replace traffic checked against a list predictor.
// Depends on plist_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps
module tb;
    import plist_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [ENTRY_W-1:0]     entry;
        logic [CNT_W-1:0]       count;
    } list_result_t;

    typedef struct packed {
        op_t                    op;
        logic [POS_W-1:0]       pos;
        logic [ENTRY_W-1:0]     val;
        logic                   typed;
        status_t                st;
        logic [ENTRY_W-1:0]     ent;
        logic [CNT_W-1:0]       cnt;
    } dir_row_t;

    typedef enum int {RD_MIXED, RD_GROW, RD_SHRINK, RD_FILL, RD_DRAIN} round_t;

    localparam int DIR_ROWS   = 25;
    localparam int RAND_ITEMS = 1300;
    localparam int DRAIN_WAIT = 80;

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{OP_REMOVE,   7'd0,   32'h0000_0000, 1'b1, ST_UNDER, 32'h0, 7'd0},
        '{OP_REMOVE,   7'd127, 32'h0000_0000, 1'b1, ST_UNDER, 32'h0, 7'd0},
        '{OP_RETRIEVE, 7'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{OP_REPLACE,  7'd0,   32'h1234_5678, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{OP_ADD,      7'd1,   32'h1234_5678, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{OP_ADD,      7'd127, 32'hFFFF_FFFF, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{OP_ADD,      7'd0,   32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 7'd1},
        '{OP_ADD,      7'd0,   32'h0000_0000, 1'b1, ST_OK,    32'h0, 7'd2},
        '{OP_ADD,      7'd2,   32'hA5A5_A5A5, 1'b1, ST_OK,    32'h0, 7'd3},
        '{OP_ADD,      7'd1,   32'h5A5A_5A5A, 1'b1, ST_OK,    32'h0, 7'd4},
        '{OP_RETRIEVE, 7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_RETRIEVE, 7'd3,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_RETRIEVE, 7'd4,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{OP_RETRIEVE, 7'd64,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{OP_REPLACE,  7'd0,   32'h8000_0001, 1'b1, ST_OK,    32'h0, 7'd4},
        '{OP_REPLACE,  7'd4,   32'hDEAD_BEEF, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{OP_RETRIEVE, 7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_REMOVE,   7'd4,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{OP_REMOVE,   7'd127, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{OP_ADD,      7'd5,   32'hCAFE_F00D, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{OP_REMOVE,   7'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_REMOVE,   7'd2,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_REMOVE,   7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_RETRIEVE, 7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{OP_REMOVE,   7'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;

    logic [ENTRY_W-1:0]       list_mem [CAPACITY];
    int                       list_len;
    list_result_t             result_q [$];

    int                       fail_cnt;
    int                       sent_cnt;
    int                       checked_cnt;
    int                       peak_len;
    int                       op_cnt [4];
    int                       stat_cnt [4];
    bit                       no_idle;
    int                       hold_req;

    positional_list_engine_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #24_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, result_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic list_result_t apply_cmd(op_t op, logic [POS_W-1:0] pos,
                                               logic [ENTRY_W-1:0] val);
        list_result_t r;
        int           p;
        int           i;
        p        = int'(pos);
        r.status = ST_OK;
        r.entry  = '0;
        case (op)
            OP_ADD:
            begin
                if (p > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            OP_REMOVE:
            begin
                if (list_len == 0)
                    r.status = ST_UNDER;
                else if (p >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    r.entry = list_mem[p];
                    for (i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_RETRIEVE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.entry = list_mem[p];
            end
            default:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    list_mem[p] = val;
            end
        endcase
        r.count = list_len[CNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_cmd(input op_t op, input logic [POS_W-1:0] pos,
                            input logic [ENTRY_W-1:0] val, input logic typed,
                            input list_result_t typed_res);
        int           gap;
        list_result_t pred;
        gap = (!no_idle && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, val, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        pred = apply_cmd(op, pos, val);
        result_q.push_back(typed ? typed_res : pred);
        sent_cnt++;
        op_cnt[op]++;
        stat_cnt[pred.status]++;
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    task automatic run_round(input round_t mode, input int n);
        int                 k;
        int                 w;
        op_t                op;
        logic [POS_W-1:0]   pos;
        logic [ENTRY_W-1:0] val;
        for (k = 0; k < n; k++)
        begin
            w = $urandom_range(0, 99);
            case (mode)
                RD_GROW:
                    op = (w < 65) ? OP_ADD : (w < 75) ? OP_REMOVE :
                         (w < 88) ? OP_RETRIEVE : OP_REPLACE;
                RD_SHRINK:
                    op = (w < 55) ? OP_REMOVE : (w < 70) ? OP_ADD :
                         (w < 85) ? OP_RETRIEVE : OP_REPLACE;
                RD_FILL:
                    op = (list_len < CAPACITY || w < 50) ? OP_ADD : op_t'($urandom_range(0, 3));
                RD_DRAIN:
                    op = (list_len > 0 || w < 50) ? OP_REMOVE : op_t'($urandom_range(0, 3));
                default:
                    op = op_t'($urandom_range(0, 3));
            endcase
            w = $urandom_range(0, 99);
            if (w < 6)
                pos = POS_W'($urandom_range(0, 127));
            else if (w < 12)
                pos = (op == OP_ADD) ? POS_W'(list_len + 1) : POS_W'(list_len);
            else if (w < 20)
                pos = '0;
            else if (w < 28)
                pos = (op == OP_ADD || list_len == 0) ? POS_W'(list_len)
                                                       : POS_W'(list_len - 1);
            else if (op == OP_ADD)
                pos = POS_W'($urandom_range(0, list_len));
            else if (list_len > 0)
                pos = POS_W'($urandom_range(0, list_len - 1));
            else
                pos = '0;
            w = $urandom_range(0, 19);
            val = (w == 0) ? '0 : (w == 1) ? '1 : ENTRY_W'($urandom());
            send_cmd(op, pos, val, 1'b0, '0);
        end
    endtask

    // receive side: random stalls, long hold-off on request, compare results
    initial
    begin
        list_result_t got;
        list_result_t want;
        int           stall_left;
        int           hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[STAT_W-1:0]);
                got.entry  = m_tdata[STAT_W +: ENTRY_W];
                got.count  = m_tdata[STAT_W+ENTRY_W +: CNT_W];
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected word, got status %0d entry %h count %0d",
                             $time, got.status, got.entry, got.count);
                    fail_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    checked_cnt++;
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        fail_cnt++;
                    end
                    if (got.entry !== want.entry)
                    begin
                        $display("%0t: entry expected %h got %h",
                                 $time, want.entry, got.entry);
                        fail_cnt++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: count expected %0d got %0d",
                                 $time, want.count, got.count);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int     i;
        int     round_idx;
        int     n;
        round_t mode;
        fail_cnt    = 0;
        sent_cnt    = 0;
        checked_cnt = 0;
        peak_len    = 0;
        list_len    = 0;
        no_idle     = 1'b0;
        hold_req    = 0;
        op_cnt      = '{default: 0};
        stat_cnt    = '{default: 0};
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_cmd(DIR_TAB[i].op, DIR_TAB[i].pos, DIR_TAB[i].val, DIR_TAB[i].typed,
                     '{DIR_TAB[i].st, DIR_TAB[i].ent, DIR_TAB[i].cnt});

        round_idx = 0;
        while (sent_cnt < DIR_ROWS + RAND_ITEMS)
        begin
            case (round_idx % 6)
                1: mode = RD_FILL;
                4: mode = RD_DRAIN;
                default: mode = round_t'($urandom_range(0, 2));
            endcase
            if (mode == RD_FILL)
                n = 2 * (CAPACITY - list_len) + 12;
            else if (mode == RD_DRAIN)
                n = 2 * list_len + 12;
            else
                n = $urandom_range(20, 60);
            if (n > DIR_ROWS + RAND_ITEMS - sent_cnt)
                n = DIR_ROWS + RAND_ITEMS - sent_cnt;
            no_idle = ($urandom_range(0, 3) == 0);
            // back up the output while commands keep coming
            if (round_idx == 2 || round_idx == 9)
                hold_req = 400;
            // let the pipe run dry before the next round
            if (round_idx % 5 == 3)
            begin
                s_tvalid <= 1'b0;
                while (result_q.size() != 0)
                    @(posedge clk);
            end
            run_round(mode, n);
            round_idx++;
        end

        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d commands: %0d add, %0d remove, %0d retrieve, %0d replace; %0d checked",
                 sent_cnt, op_cnt[OP_ADD], op_cnt[OP_REMOVE], op_cnt[OP_RETRIEVE],
                 op_cnt[OP_REPLACE], checked_cnt);
        $display("status ok %0d, range %0d, underflow %0d, full %0d; peak list length %0d",
                 stat_cnt[ST_OK], stat_cnt[ST_RANGE], stat_cnt[ST_UNDER],
                 stat_cnt[ST_FULL], peak_len);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- positional_list_engine_core.f -----
rtl/core/plist_pkg.sv
rtl/core/plist_ctrl.sv
rtl/core/plist_dp.sv
rtl/core/positional_list_engine_core.sv
rtl/core/plist_chk.sv
bench/tb.sv
